// File: hw/rtl/csms_pkg.sv
// ----------------------------------------------------------------------------
// csms_pkg
// Shared types, constants and helpers of the card-selected melody sequencer.
// ----------------------------------------------------------------------------
package csms_pkg;

	localparam int unsigned NOTES_PER_MELODY = 1024;
	localparam int unsigned MELODY_COUNT     = 2;
	localparam int unsigned STORE_DEPTH      = NOTES_PER_MELODY * MELODY_COUNT;
	localparam int unsigned STORE_AW         = $clog2(STORE_DEPTH);

	localparam int unsigned FREQ_W   = 13;
	localparam int unsigned DUR_W    = 16;
	localparam int unsigned ENTRY_W  = FREQ_W + DUR_W;
	localparam int unsigned POS_W    = 11;
	localparam int unsigned ADDR_W   = 10;
	localparam int unsigned UID_W    = 32;
	localparam int unsigned CFG_W    = 32;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [UID_W-1:0] CARD0_ID_RST = 32'hB017E0A4;
	localparam logic [UID_W-1:0] CARD1_ID_RST = 32'h7DD48589;

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_TICK   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		STAT_NONE     = 3'd0,
		STAT_REJECT   = 3'd1,
		STAT_STARTED  = 3'd2,
		STAT_STOPPED  = 3'd3,
		STAT_FINISHED = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CARD0_ID = 2'd0,
		CFG_CARD1_ID = 2'd1,
		CFG_MEL0_LEN = 2'd2,
		CFG_MEL1_LEN = 2'd3
	} cfg_index_t;

	typedef enum logic {
		CS_IDLE  = 1'b0,
		CS_FETCH = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		kind_t             kind;
		logic              melody_select;
		logic [ADDR_W-1:0] note_address;
		logic [FREQ_W-1:0] load_frequency;
		logic [DUR_W-1:0]  load_duration;
		logic [UID_W-1:0]  card_uid;
	} in_item_t;

	typedef struct packed {
		status_t           status;
		logic [FREQ_W-1:0] tone_frequency;
		logic [DUR_W-1:0]  tone_duration;
		logic [ADDR_W-1:0] note_number;
		logic              playing_melody;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic fetch_done;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_fetch;
		logic out_busy;
	} dp_status_t;

	// Length register limited to the notes a melody can hold.
	function automatic logic [POS_W-1:0] clamp_len(input logic [POS_W-1:0] n);
		logic [POS_W-1:0] r;
		r = n;
		if (32'(n) > NOTES_PER_MELODY) begin
			r = POS_W'(NOTES_PER_MELODY);
		end
		return r;
	endfunction

	// Flat store index of a note of a melody.
	function automatic logic [STORE_AW-1:0] store_index(input logic m,
		input logic [POS_W-1:0] pos);
		return STORE_AW'(32'(m) * NOTES_PER_MELODY + 32'(pos));
	endfunction

endpackage

// File: hw/rtl/csms_ram.sv
// ----------------------------------------------------------------------------
// csms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csms_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/csms_ctrl.sv
// ----------------------------------------------------------------------------
// csms_ctrl
// Controller: takes items and sequences the note store read.
// ----------------------------------------------------------------------------
module csms_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  csms_pkg::dp_status_t sts,
	output logic                 in_stall,
	output csms_pkg::dp_cmd_t    cmd
);
	import csms_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			CS_IDLE: begin
				if (in_valid && !sts.out_busy && sts.need_fetch) begin
					state_nxt = CS_FETCH;
				end
			end
			CS_FETCH: begin
				state_nxt = CS_IDLE;
			end
			default: begin
				state_nxt = CS_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall       = 1'b1;
		cmd.take       = 1'b0;
		cmd.fetch_done = 1'b0;
		case (state_q)
			CS_IDLE: begin
				in_stall = sts.out_busy;
				cmd.take = in_valid && !sts.out_busy;
			end
			CS_FETCH: begin
				cmd.fetch_done = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// File: hw/rtl/csms_dp.sv
// ----------------------------------------------------------------------------
// csms_dp
// Datapath: configuration, playback state, note store and result register.
// ----------------------------------------------------------------------------
module csms_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic [csms_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [csms_pkg::CFG_W-1:0]             cfg_data,
	input  csms_pkg::in_item_t                     in_item,
	input  logic                                   out_stall,
	input  csms_pkg::dp_cmd_t                      cmd,
	output csms_pkg::dp_status_t                   sts,
	output logic                                   out_valid,
	output csms_pkg::out_item_t                    out_item
);
	import csms_pkg::*;

	logic [UID_W-1:0]  card0_q;
	logic [UID_W-1:0]  card1_q;
	logic [POS_W-1:0]  len0_q;
	logic [POS_W-1:0]  len1_q;

	logic              play_q;
	logic              melody_q;
	logic [POS_W-1:0]  pos_q;
	logic [DUR_W-1:0]  remain_q;
	logic [FREQ_W-1:0] tone_q;
	logic              out_valid_q;
	out_item_t         out_item_q;

	logic              play_nxt;
	logic              melody_nxt;
	logic [POS_W-1:0]  pos_nxt;
	logic [DUR_W-1:0]  remain_nxt;
	logic [FREQ_W-1:0] tone_nxt;
	status_t           stat_nxt;
	logic              need_fetch;

	logic              hit0;
	logic              hit1;
	logic [POS_W-1:0]  ins_len;
	logic [POS_W-1:0]  act_len;
	logic [POS_W-1:0]  next_pos;

	logic              st_we;
	logic [STORE_AW-1:0] st_waddr;
	logic [STORE_AW-1:0] st_raddr;
	logic [ENTRY_W-1:0]  st_rdata;

	cfg_index_t cfg_sel;
	assign cfg_sel = cfg_index_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			card0_q <= CARD0_ID_RST;
			card1_q <= CARD1_ID_RST;
			len0_q  <= '0;
			len1_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_sel)
				CFG_CARD0_ID: card0_q <= cfg_data[UID_W-1:0];
				CFG_CARD1_ID: card1_q <= cfg_data[UID_W-1:0];
				CFG_MEL0_LEN: len0_q  <= cfg_data[POS_W-1:0];
				CFG_MEL1_LEN: len1_q  <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	assign hit0     = (in_item.card_uid == card0_q);
	assign hit1     = (MELODY_COUNT > 1) && (in_item.card_uid == card1_q);
	assign ins_len  = clamp_len(hit1 ? len1_q : len0_q);
	assign act_len  = clamp_len(melody_q ? len1_q : len0_q);
	assign next_pos = pos_q + POS_W'(1);

	// Decide the effect of the item at the input.
	always_comb begin
		play_nxt   = play_q;
		melody_nxt = melody_q;
		pos_nxt    = pos_q;
		remain_nxt = remain_q;
		tone_nxt   = tone_q;
		stat_nxt   = STAT_NONE;
		need_fetch = 1'b0;
		case (in_item.kind)
			KIND_LOAD: ;
			KIND_INSERT: begin
				if (!play_q) begin
					if (!(hit0 || hit1)) begin
						stat_nxt = STAT_REJECT;
					end else begin
						melody_nxt = hit1;
						pos_nxt    = '0;
						if (ins_len == '0) begin
							tone_nxt   = '0;
							remain_nxt = '0;
							stat_nxt   = STAT_FINISHED;
						end else begin
							need_fetch = 1'b1;
						end
					end
				end
			end
			KIND_REMOVE: begin
				if (play_q) begin
					play_nxt   = 1'b0;
					tone_nxt   = '0;
					remain_nxt = '0;
					stat_nxt   = STAT_STOPPED;
				end
			end
			KIND_TICK: begin
				if (play_q) begin
					if (remain_q > DUR_W'(1)) begin
						remain_nxt = remain_q - DUR_W'(1);
					end else if (next_pos >= act_len) begin
						play_nxt   = 1'b0;
						tone_nxt   = '0;
						remain_nxt = '0;
						stat_nxt   = STAT_FINISHED;
					end else begin
						pos_nxt    = next_pos;
						need_fetch = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	assign sts.need_fetch = need_fetch;
	assign sts.out_busy   = out_valid_q && out_stall;

	// Note store: loads write, note starts read in the cycle before the fetch.
	assign st_we    = cmd.take && (in_item.kind == KIND_LOAD)
		&& (32'(in_item.melody_select) < MELODY_COUNT)
		&& (32'(in_item.note_address) < NOTES_PER_MELODY);
	assign st_waddr = store_index(in_item.melody_select, POS_W'(in_item.note_address));
	assign st_raddr = store_index(melody_nxt, pos_nxt);

	csms_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata ({in_item.load_frequency, in_item.load_duration}),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_q   <= 1'b0;
			melody_q <= 1'b0;
			pos_q    <= '0;
			remain_q <= '0;
			tone_q   <= '0;
		end else if (cmd.fetch_done) begin
			play_q   <= 1'b1;
			tone_q   <= st_rdata[ENTRY_W-1:DUR_W];
			remain_q <= st_rdata[DUR_W-1:0];
		end else if (cmd.take) begin
			play_q   <= play_nxt;
			melody_q <= melody_nxt;
			pos_q    <= pos_nxt;
			remain_q <= remain_nxt;
			tone_q   <= tone_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fetch_done || (cmd.take && !need_fetch)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch_done) begin
			out_item_q.status         <= STAT_STARTED;
			out_item_q.tone_frequency <= st_rdata[ENTRY_W-1:DUR_W];
			out_item_q.tone_duration  <= st_rdata[DUR_W-1:0];
			out_item_q.note_number    <= pos_q[ADDR_W-1:0];
			out_item_q.playing_melody <= melody_q;
		end else if (cmd.take && !need_fetch) begin
			out_item_q.status         <= stat_nxt;
			out_item_q.tone_frequency <= tone_nxt;
			out_item_q.tone_duration  <= '0;
			out_item_q.note_number    <= pos_nxt[ADDR_W-1:0];
			out_item_q.playing_melody <= melody_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// File: hw/rtl/card_selected_melody_sequencer_core.sv
// ----------------------------------------------------------------------------
// card_selected_melody_sequencer_core
// Plays a stored tone sequence selected by a card ID, timed by ms ticks.
// ----------------------------------------------------------------------------
//
//   channel   signals                          transfer when
//   --------  -------------------------------  ----------------------------
//   input     in_valid, in_stall, in_item      in_valid && !in_stall
//   output    out_valid, out_stall, out_item   out_valid && !out_stall
//   config    cfg_write, cfg_index, cfg_data   cfg_write
//
// An item that starts a note (card insert that starts a melody, or a tick
// that moves to the next note) passes through the fetch state: the note
// store has a registered read port, so the note is captured in that state.
// Every input transfer yields exactly one result transfer.
// Reset clears the playback state and restores the register defaults; the
// note store has no reset and holds garbage until loaded.
// A stalled result holds in the output register; the input stalls only
// while a result is held back or a note read is in flight.
// ----------------------------------------------------------------------------
module card_selected_melody_sequencer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [csms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [csms_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  csms_pkg::in_item_t             in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output csms_pkg::out_item_t            out_item
);
	import csms_pkg::*;

	// Commands and status between the controller and the datapath.
	dp_cmd_t    cmd;
	dp_status_t sts;

	// Controller: hands items to the datapath and owns the fetch cycle.
	csms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// Datapath: registers, playback state, note store, result register.
	csms_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

endmodule

// File: hw/rtl/csms_checker.sv
// ----------------------------------------------------------------------------
// csms_checker
// Port-level checks of the melody sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module csms_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_stall,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  csms_pkg::out_item_t            out_item
);
	import csms_pkg::*;

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// Hold off new input while a result is blocked.
	a_in_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while result blocked");

	// Duration is reported only with a note start.
	a_dur_only_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status != STAT_STARTED) |-> out_item.tone_duration == '0)
		else $error("duration without note start");

	// Stop and finish leave the tone silent.
	a_silent_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((out_item.status == STAT_STOPPED) || (out_item.status == STAT_FINISHED))
		|-> out_item.tone_frequency == '0)
		else $error("tone not silent after stop or finish");

endmodule

bind card_selected_melody_sequencer_core csms_checker u_csms_checker (.*);
